@@ rtl/ahrc_pkg.sv @@
// ahrc_pkg: shared types and constants for the arm hold-and-ramp controller.
// Used by ahrc_ctrl, ahrc_dpath and arm_hold_and_ramp_control; no dependencies.
package ahrc_pkg;

  // Default parameter values
  localparam int ANGLE_BITS_DEF     = 12;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int ANGLE_FIELD_W = 12;
  localparam int GAIN_W        = 16;
  localparam int POWER_W       = 7;
  localparam int DRIVE_W       = 8;
  localparam int SPEED_W       = 11;
  localparam int TIME_W        = 16;
  localparam int INTEG_W       = 20;
  localparam int STEP_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Config reset values
  localparam int HOLD_GAIN_INITIAL_RST = 9175;
  localparam int HOLD_GAIN_SETTLED_RST = 19661;
  localparam int INTEGRAL_GAIN_RST     = 33;
  localparam int SPEED_GAIN_RST        = 655;
  localparam int MAX_HOLD_POWER_RST    = 127;
  localparam int UPPER_LIMIT_RST       = 4095;
  localparam int LOWER_LIMIT_RST       = 0;
  localparam int RAMP_START_RST        = 0;

  // Control constants
  localparam int RELATCH_MS        = 300;
  localparam int SETTLE_MS         = 400;
  localparam int RELATCH_SPEED     = 6;
  localparam int SETTLE_SPEED      = 10;
  localparam int CAP_TERM          = 5;
  localparam int MIN_DRIVE         = 5;
  localparam int LIMIT_DRIVE       = 15;
  localparam int UPPER_MARGIN      = 50;
  localparam int LOWER_HOLD_MARGIN = 75;
  localparam int LOWER_RAMP_MARGIN = 50;
  localparam int RAMP_FAST_ABOVE   = 90;
  localparam int RAMP_MAX          = 127;
  localparam int RAMP_STEP_INIT    = 2;
  localparam int RAMP_STEP_FAST    = 3;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_GAIN_INITIAL = 3'd0,
    REG_HOLD_GAIN_SETTLED = 3'd1,
    REG_INTEGRAL_GAIN     = 3'd2,
    REG_SPEED_GAIN        = 3'd3,
    REG_MAX_HOLD_POWER    = 3'd4,
    REG_UPPER_ANGLE_LIMIT = 3'd5,
    REG_LOWER_ANGLE_LIMIT = 3'd6,
    REG_RAMP_START_POWER  = 3'd7
  } cfg_reg_t;

  // Arm control mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HOLD = 2'd1,
    MODE_RAMP = 2'd2
  } mode_t;

  // Shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_INTEG = 2'd0,
    MUL_KP    = 2'd1,
    MUL_KD    = 2'd2
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     lock_tick;
    logic     ramp_tick;
    logic     hold_prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_check;
    logic     div_step;
    logic     div_write;
    logic     lat_mag;
    logic     lat_dterm;
    logic     hold_emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_lock;
    logic is_ramp;
    logic cap_hit;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/ahrc_dpath.sv @@
// ahrc_dpath: config registers, control state, shared multiplier, cap divider,
// ramp logic and output word register. Depends on ahrc_pkg; driven by ahrc_ctrl.
module ahrc_dpath import ahrc_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic [ANGLE_BITS-1:0]     arm_angle,
  input  logic signed [SPEED_W-1:0] arm_speed,
  input  logic                      forward_button,
  input  logic                      backward_button,
  input  logic                      lock_request,
  input  logic                      lock_task_busy,
  input  logic [TIME_W-1:0]         now_ms,
  input  logic                      result_stall,
  output logic                      result_valid,
  output logic signed [DRIVE_W-1:0] drive_power,
  output logic                      stop_lock_task,
  input  cmd_t                      cmd,
  output sts_t                      sts
);

  localparam int AW    = ANGLE_BITS;
  localparam int FB    = GAIN_FRAC_BITS;
  localparam int AMW   = (AW < ANGLE_FIELD_W) ? AW : ANGLE_FIELD_W;
  localparam int PW    = GAIN_W + INTEG_W;
  localparam int TW    = PW - FB;
  localparam int SW    = TW + 2;
  localparam int DIV_N = FB + 3;
  localparam int QW    = (DIV_N > INTEG_W) ? DIV_N : INTEG_W;
  localparam logic [PW-1:0]      CAP_LIMIT = PW'(CAP_TERM) << FB;
  localparam logic [INTEG_W-1:0] INTEG_MAX = {INTEG_W{1'b1}};

  // Config registers
  logic [GAIN_W-1:0]  kp_init, kp_settled, ki, kd;
  logic [POWER_W-1:0] max_pwr, ramp_start;
  logic [AW-1:0]      upper, lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_init    <= GAIN_W'(HOLD_GAIN_INITIAL_RST);
      kp_settled <= GAIN_W'(HOLD_GAIN_SETTLED_RST);
      ki         <= GAIN_W'(INTEGRAL_GAIN_RST);
      kd         <= GAIN_W'(SPEED_GAIN_RST);
      max_pwr    <= POWER_W'(MAX_HOLD_POWER_RST);
      upper      <= AW'(AMW'(UPPER_LIMIT_RST));
      lower      <= AW'(LOWER_LIMIT_RST);
      ramp_start <= POWER_W'(RAMP_START_RST);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_HOLD_GAIN_INITIAL: kp_init    <= cfg_data;
        REG_HOLD_GAIN_SETTLED: kp_settled <= cfg_data;
        REG_INTEGRAL_GAIN:     ki         <= cfg_data;
        REG_SPEED_GAIN:        kd         <= cfg_data;
        REG_MAX_HOLD_POWER:    max_pwr    <= cfg_data[POWER_W-1:0];
        REG_UPPER_ANGLE_LIMIT: upper      <= AW'(cfg_data[AMW-1:0]);
        REG_LOWER_ANGLE_LIMIT: lower      <= AW'(cfg_data[AMW-1:0]);
        REG_RAMP_START_POWER:  ramp_start <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured tick word
  logic [AW-1:0]             angle_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic                      fwd_r, bwd_r, lock_r, busy_r;
  logic [TIME_W-1:0]         now_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= AW'(arm_angle[AMW-1:0]);
      speed_r <= arm_speed;
      fwd_r   <= forward_button;
      bwd_r   <= backward_button;
      lock_r  <= lock_request;
      busy_r  <= lock_task_busy;
      now_r   <= now_ms;
    end
  end

  // Control state
  mode_t              mode;
  logic [AW-1:0]      target;
  logic [TIME_W-1:0]  hold_start;
  logic [INTEG_W-1:0] integ;
  logic               settled;
  logic [POWER_W-1:0] ramp_pwr;
  logic [STEP_W-1:0]  ramp_step;

  // Work registers
  logic [PW-1:0]     prod;
  logic [TW-1:0]     mag_r, dterm_r;
  logic [GAIN_W-1:0] rem;
  logic [DIV_N-1:0]  qd;

  // Common terms
  logic [SPEED_W-1:0] aspd;
  logic               hold_entry, ramp_entry;
  logic [TIME_W-1:0]  start_eff, elapsed;
  logic               relatch, settle;
  logic               err_neg;
  logic [AW-1:0]      aerr;
  logic [GAIN_W-1:0]  kp, mul_a;
  logic [INTEG_W-1:0] mul_b;
  logic [INTEG_W:0]   integ_sum;
  logic [INTEG_W-1:0] integ_add;
  logic [GAIN_W:0]    trial, trial_diff;
  logic               trial_ge;
  logic [QW-1:0]      quot_ext;
  logic [AW:0]        angle_x, above_upper_x, lower_hold_x, lower_ramp_x;
  logic               near_upper, near_lower_hold, near_lower_ramp;

  assign aspd       = speed_r[SPEED_W-1] ? (~speed_r + SPEED_W'(1)) : speed_r;
  assign hold_entry = (mode != MODE_HOLD);
  assign ramp_entry = (mode != MODE_RAMP);
  assign start_eff  = hold_entry ? now_r : hold_start;
  assign elapsed    = now_r - start_eff;
  assign relatch    = (elapsed < TIME_W'(RELATCH_MS)) && (aspd >= SPEED_W'(RELATCH_SPEED));
  assign settle     = (elapsed > TIME_W'(SETTLE_MS)) && (aspd <= SPEED_W'(SETTLE_SPEED));
  assign err_neg    = angle_r < target;
  assign aerr       = err_neg ? (target - angle_r) : (angle_r - target);
  assign kp         = settled ? kp_settled : kp_init;

  always_comb begin
    case (cmd.mul_sel)
      MUL_KP: begin
        mul_a = kp;
        mul_b = INTEG_W'(aerr);
      end
      MUL_KD: begin
        mul_a = kd;
        mul_b = INTEG_W'(aspd);
      end
      default: begin
        mul_a = ki;
        mul_b = integ;
      end
    endcase
  end

  assign integ_sum = {1'b0, integ} + (INTEG_W+1)'(aerr);
  assign integ_add = integ_sum[INTEG_W] ? INTEG_MAX : integ_sum[INTEG_W-1:0];

  // Restoring divider, one quotient bit per cycle
  assign trial      = {rem, qd[DIV_N-1]};
  assign trial_ge   = trial >= {1'b0, ki};
  assign trial_diff = trial - {1'b0, ki};
  assign quot_ext   = QW'(qd);

  // Angle window checks
  assign angle_x         = (AW+1)'(angle_r);
  assign above_upper_x   = angle_x + (AW+1)'(UPPER_MARGIN);
  assign lower_hold_x    = (AW+1)'(lower) + (AW+1)'(LOWER_HOLD_MARGIN);
  assign lower_ramp_x    = (AW+1)'(lower) + (AW+1)'(LOWER_RAMP_MARGIN);
  assign near_upper      = above_upper_x > (AW+1)'(upper);
  assign near_lower_hold = angle_x < lower_hold_x;
  assign near_lower_ramp = angle_x < lower_ramp_x;

  // Hold drive: |P| + I + D, clamped, min 5 (zero while P is zero), then angle overrides
  logic [SW-1:0]             total;
  logic [POWER_W-1:0]        hmag_clamp, hmag;
  logic signed [DRIVE_W-1:0] hold_drive;

  always_comb begin
    total      = SW'(mag_r) + SW'(dterm_r) + SW'(prod[PW-1:FB]);
    hmag_clamp = (total > SW'(max_pwr)) ? max_pwr : total[POWER_W-1:0];
    if (mag_r == '0) begin
      hmag = '0;
    end else if (hmag_clamp < POWER_W'(MIN_DRIVE)) begin
      hmag = POWER_W'(MIN_DRIVE);
    end else begin
      hmag = hmag_clamp;
    end
    hold_drive = err_neg ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
    if (near_upper) begin
      hold_drive = -DRIVE_W'(LIMIT_DRIVE);
    end
    if (near_lower_hold) begin
      hold_drive = DRIVE_W'(LIMIT_DRIVE);
    end
  end

  // Ramp tick
  logic [DRIVE_W-1:0]        rp0, rp1;
  logic [STEP_W-1:0]         st0, step_n;
  logic [POWER_W-1:0]        rp2, rp3;
  logic                      fwd_only, bwd_only;
  logic signed [DRIVE_W-1:0] ramp_drive;

  always_comb begin
    fwd_only = fwd_r && !bwd_r;
    bwd_only = bwd_r && !fwd_r;
    rp0      = ramp_entry ? {1'b0, ramp_start} : {1'b0, ramp_pwr};
    st0      = ramp_entry ? STEP_W'(RAMP_STEP_INIT) : ramp_step;
    rp1      = rp0 + DRIVE_W'(st0);
    step_n   = (rp1 > DRIVE_W'(RAMP_FAST_ABOVE)) ? STEP_W'(RAMP_STEP_FAST) : st0;
    rp2      = (rp1 > DRIVE_W'(RAMP_MAX)) ? POWER_W'(RAMP_MAX) : rp1[POWER_W-1:0];
    if ((fwd_only && near_lower_ramp) || (bwd_only && near_upper)) begin
      rp3 = POWER_W'(LIMIT_DRIVE);
    end else begin
      rp3 = rp2;
    end
    if (fwd_only) begin
      ramp_drive = $signed({1'b0, rp3});
    end else if (bwd_only) begin
      ramp_drive = -$signed({1'b0, rp3});
    end else begin
      ramp_drive = '0;
    end
  end

  // State updates
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      target     <= '0;
      hold_start <= '0;
      integ      <= '0;
      settled    <= 1'b0;
      ramp_pwr   <= '0;
      ramp_step  <= STEP_W'(RAMP_STEP_INIT);
    end else begin
      if (cmd.lock_tick) begin
        mode <= MODE_IDLE;
      end
      if (cmd.ramp_tick) begin
        mode      <= MODE_RAMP;
        ramp_pwr  <= rp3;
        ramp_step <= step_n;
      end
      if (cmd.hold_prep) begin
        mode       <= MODE_HOLD;
        hold_start <= start_eff;
        if (hold_entry || relatch) begin
          target <= angle_r;
        end
        if (hold_entry) begin
          integ <= '0;
        end
        settled <= (settled && !hold_entry) || settle;
      end
      if (cmd.cap_check && !sts.cap_hit) begin
        integ <= integ_add;
      end
      if (cmd.div_write) begin
        integ <= (quot_ext > QW'(INTEG_MAX)) ? INTEG_MAX : quot_ext[INTEG_W-1:0];
      end
    end
  end

  // Multiplier, divider and term registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.lat_mag) begin
      mag_r <= prod[PW-1:FB];
    end
    if (cmd.lat_dterm) begin
      dterm_r <= prod[PW-1:FB];
    end
    if (cmd.cap_check) begin
      rem <= '0;
      qd  <= CAP_LIMIT[DIV_N-1:0];
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
      qd  <= {qd[DIV_N-2:0], trial_ge};
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.ramp_tick || cmd.hold_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ramp_tick) begin
      drive_power    <= ramp_drive;
      stop_lock_task <= ramp_entry;
    end else if (cmd.hold_emit) begin
      drive_power    <= hold_drive;
      stop_lock_task <= 1'b0;
    end
  end

  assign sts.is_lock  = lock_r || busy_r;
  assign sts.is_ramp  = fwd_r || bwd_r;
  assign sts.cap_hit  = prod > CAP_LIMIT;
  assign sts.out_free = !result_valid || !result_stall;

endmodule

@@ rtl/ahrc_ctrl.sv @@
// ahrc_ctrl: sequencer for one control tick (decode, hold multiply chain,
// cap divider loop, ramp step, emit). Depends on ahrc_pkg; drives ahrc_dpath.
module ahrc_ctrl import ahrc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic tick_valid,
  output logic tick_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int DIV_N = GAIN_FRAC_BITS + 3;
  localparam int CW    = $clog2(DIV_N);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECODE = 12'b0000_0000_0010,
    S_PREP   = 12'b0000_0000_0100,
    S_MULI   = 12'b0000_0000_1000,
    S_CHECK  = 12'b0000_0001_0000,
    S_DIV    = 12'b0000_0010_0000,
    S_DIVW   = 12'b0000_0100_0000,
    S_MULP   = 12'b0000_1000_0000,
    S_MULD   = 12'b0001_0000_0000,
    S_MULN   = 12'b0010_0000_0000,
    S_SUM    = 12'b0100_0000_0000,
    S_RAMP   = 12'b1000_0000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  assign tick_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = MUL_INTEG;
    case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_lock) begin
          cmd.lock_tick = 1'b1;
          state_next    = S_IDLE;
        end else if (sts.is_ramp) begin
          state_next = S_RAMP;
        end else begin
          state_next = S_PREP;
        end
      end
      S_RAMP: begin
        if (sts.out_free) begin
          cmd.ramp_tick = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PREP: begin
        cmd.hold_prep = 1'b1;
        state_next    = S_MULI;
      end
      S_MULI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INTEG;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        cmd.cap_check = 1'b1;
        if (sts.cap_hit) begin
          cnt_next   = CW'(DIV_N - 1);
          state_next = S_DIV;
        end else begin
          state_next = S_MULP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DIVW;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      S_DIVW: begin
        cmd.div_write = 1'b1;
        state_next    = S_MULP;
      end
      S_MULP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KP;
        state_next  = S_MULD;
      end
      S_MULD: begin
        cmd.lat_mag = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KD;
        state_next  = S_MULN;
      end
      S_MULN: begin
        cmd.lat_dterm = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_INTEG;
        state_next    = S_SUM;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.hold_emit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/arm_hold_and_ramp_control.sv @@
// arm_hold_and_ramp_control: top level of the arm hold-and-ramp controller.
// Instantiates ahrc_ctrl and ahrc_dpath; uses ahrc_pkg.
//
//   channel  direction  handshake                  payload
//   tick     in         tick_valid / tick_stall    arm_angle, arm_speed, buttons, lock, now_ms
//   result   out        result_valid / result_stall  drive_power, stop_lock_task
//   cfg      in         cfg_write                  cfg_index, cfg_data
//
// A tick word is taken only when the sequencer is idle. A hold tick runs decode, prep, the
// integral multiply and cap check, the P and D multiplies and the sum, plus the restoring
// cap divider (one quotient bit per cycle) when the integral cap fires. The single shared
// multiplier sets the hold length. A stalled result word sits in the output register while
// the next tick is worked; that tick waits only at its final step.
// Synchronous reset restores the config defaults and idle mode.
module arm_hold_and_ramp_control import ahrc_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // config write port
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // tick words in
  input  logic                      tick_valid,
  output logic                      tick_stall,
  input  logic [ANGLE_BITS-1:0]     arm_angle,
  input  logic signed [SPEED_W-1:0] arm_speed,
  input  logic                      forward_button,
  input  logic                      backward_button,
  input  logic                      lock_request,
  input  logic                      lock_task_busy,
  input  logic [TIME_W-1:0]         now_ms,
  // result words out
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [DRIVE_W-1:0] drive_power,
  output logic                      stop_lock_task
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: one-hot FSM stepping the datapath through each tick
  ahrc_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: config, control state, shared multiplier, divider, output register
  ahrc_dpath #(
    .ANGLE_BITS    (ANGLE_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .arm_angle      (arm_angle),
    .arm_speed      (arm_speed),
    .forward_button (forward_button),
    .backward_button(backward_button),
    .lock_request   (lock_request),
    .lock_task_busy (lock_task_busy),
    .now_ms         (now_ms),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .drive_power    (drive_power),
    .stop_lock_task (stop_lock_task),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

@@ test/arm_drive_checker.sv @@
`timescale 1ns / 100ps
// arm_drive_checker: shadow model and scoreboard for arm_hold_and_ramp_control.
// Watches the register port and both word channels; depends on ahrc_pkg only.
module arm_drive_checker import ahrc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          tick_valid,
  input  logic                          tick_stall,
  input  logic [ANGLE_FIELD_W-1:0]      arm_angle,
  input  logic signed [SPEED_W-1:0]     arm_speed,
  input  logic                          forward_button,
  input  logic                          backward_button,
  input  logic                          lock_request,
  input  logic                          lock_task_busy,
  input  logic [TIME_W-1:0]             now_ms,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic signed [DRIVE_W-1:0]     drive_power,
  input  logic                          stop_lock_task,
  output int                            mismatches,
  output int                            outstanding
);

  localparam int     FRAC       = GAIN_FRAC_BITS_DEF;
  localparam longint CAP_LEVEL  = longint'(CAP_TERM) << FRAC;
  localparam longint INTEG_FULL = (longint'(1) << INTEG_W) - 1;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      stop;
  } drive_word_t;

  drive_word_t expected_words[$];
  int fail_count = 0;

  // shadow registers
  logic [GAIN_W-1:0]        kp_initial, kp_settled, ki, kd;
  logic [POWER_W-1:0]       max_power, ramp_start;
  logic [ANGLE_FIELD_W-1:0] upper_limit, lower_limit;

  // shadow control state
  mode_t                    mode;
  logic [ANGLE_FIELD_W-1:0] target;
  logic [TIME_W-1:0]        hold_start;
  logic [INTEG_W-1:0]       integ;
  logic                     settled;
  logic [7:0]               ramp_power;
  logic [STEP_W-1:0]        ramp_step;

  assign mismatches = fail_count;

  function automatic logic signed [DRIVE_W-1:0] hold_drive(
    input logic [ANGLE_FIELD_W-1:0] angle,
    input int                       aspd,
    input logic [TIME_W-1:0]        now
  );
    logic [TIME_W-1:0] elapsed;
    logic [GAIN_W-1:0] kp;
    int                err, aerr, drive;
    longint            mag, iterm, dterm, sum;
    if (mode != MODE_HOLD) begin
      mode       = MODE_HOLD;
      target     = angle;
      hold_start = now;
      integ      = '0;
      settled    = 1'b0;
    end
    elapsed = now - hold_start;
    if (elapsed < RELATCH_MS && aspd >= RELATCH_SPEED) target = angle;
    if (elapsed > SETTLE_MS && aspd <= SETTLE_SPEED) settled = 1'b1;
    kp = settled ? kp_settled : kp_initial;

    err  = int'(angle) - int'(target);
    aerr = (err < 0) ? -err : err;
    mag  = (longint'(kp) * aerr) >> FRAC;

    // integral: clip back to the cap once ki*integ passes it, else accumulate
    if (longint'(ki) * longint'(integ) > CAP_LEVEL) begin
      sum   = CAP_LEVEL / longint'(ki);
      integ = sum[INTEG_W-1:0];
    end else begin
      sum   = longint'(integ) + aerr;
      integ = (sum > INTEG_FULL) ? '1 : sum[INTEG_W-1:0];
    end

    if (mag != 0) begin
      iterm = (longint'(ki) * longint'(integ)) >> FRAC;
      dterm = (longint'(kd) * aspd) >> FRAC;
      mag   = mag + iterm + dterm;
      if (mag > longint'(max_power)) mag = longint'(max_power);
      if (mag < MIN_DRIVE) mag = MIN_DRIVE;
    end
    drive = (err < 0) ? -int'(mag) : int'(mag);

    if (int'(angle) > int'(upper_limit) - UPPER_MARGIN) drive = -LIMIT_DRIVE;
    if (int'(angle) < int'(lower_limit) + LOWER_HOLD_MARGIN) drive = LIMIT_DRIVE;
    return drive[DRIVE_W-1:0];
  endfunction

  function automatic drive_word_t ramp_word(
    input logic [ANGLE_FIELD_W-1:0] angle,
    input logic                     fwd,
    input logic                     bwd
  );
    drive_word_t w;
    w.stop = 1'b0;
    if (mode != MODE_RAMP) begin
      mode       = MODE_RAMP;
      ramp_power = {1'b0, ramp_start};
      ramp_step  = STEP_W'(RAMP_STEP_INIT);
      w.stop     = 1'b1;
    end
    ramp_power = ramp_power + ramp_step;
    if (int'(ramp_power) > RAMP_FAST_ABOVE) ramp_step = STEP_W'(RAMP_STEP_FAST);
    if (int'(ramp_power) > RAMP_MAX) ramp_power = 8'(RAMP_MAX);
    if (fwd && !bwd) begin
      if (int'(angle) < int'(lower_limit) + LOWER_RAMP_MARGIN) ramp_power = 8'(LIMIT_DRIVE);
      w.drive = ramp_power;
    end else if (!fwd && bwd) begin
      if (int'(angle) > int'(upper_limit) - UPPER_MARGIN) ramp_power = 8'(LIMIT_DRIVE);
      w.drive = -ramp_power;
    end else begin
      w.drive = '0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    drive_word_t want;
    int          aspd;
    if (rst) begin
      kp_initial  = GAIN_W'(HOLD_GAIN_INITIAL_RST);
      kp_settled  = GAIN_W'(HOLD_GAIN_SETTLED_RST);
      ki          = GAIN_W'(INTEGRAL_GAIN_RST);
      kd          = GAIN_W'(SPEED_GAIN_RST);
      max_power   = POWER_W'(MAX_HOLD_POWER_RST);
      upper_limit = ANGLE_FIELD_W'(UPPER_LIMIT_RST);
      lower_limit = ANGLE_FIELD_W'(LOWER_LIMIT_RST);
      ramp_start  = POWER_W'(RAMP_START_RST);
      mode        = MODE_IDLE;
      target      = '0;
      hold_start  = '0;
      integ       = '0;
      settled     = 1'b0;
      ramp_power  = '0;
      ramp_step   = STEP_W'(RAMP_STEP_INIT);
      expected_words.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_HOLD_GAIN_INITIAL: kp_initial  = cfg_data;
          REG_HOLD_GAIN_SETTLED: kp_settled  = cfg_data;
          REG_INTEGRAL_GAIN:     ki          = cfg_data;
          REG_SPEED_GAIN:        kd          = cfg_data;
          REG_MAX_HOLD_POWER:    max_power   = cfg_data[POWER_W-1:0];
          REG_UPPER_ANGLE_LIMIT: upper_limit = cfg_data[ANGLE_FIELD_W-1:0];
          REG_LOWER_ANGLE_LIMIT: lower_limit = cfg_data[ANGLE_FIELD_W-1:0];
          REG_RAMP_START_POWER:  ramp_start  = cfg_data[POWER_W-1:0];
          default: ;
        endcase
      end

      // retire first: a word leaving now can never belong to a tick taken now
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected drive word: drive_power=%0d stop_lock_task=%0b",
                 drive_power, stop_lock_task);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (drive_power !== want.drive) begin
            $error("drive_power: expected %0d, got %0d", $signed(want.drive), drive_power);
            fail_count++;
          end
          if (stop_lock_task !== want.stop) begin
            $error("stop_lock_task: expected %0b, got %0b", want.stop, stop_lock_task);
            fail_count++;
          end
        end
      end

      if (tick_valid && !tick_stall) begin
        aspd = (arm_speed < 0) ? -int'(arm_speed) : int'(arm_speed);
        if (lock_request || lock_task_busy) begin
          mode = MODE_IDLE;
        end else if (!forward_button && !backward_button) begin
          want.drive = hold_drive(arm_angle, aspd, now_ms);
          want.stop  = 1'b0;
          expected_words.push_back(want);
        end else begin
          expected_words.push_back(ramp_word(arm_angle, forward_button, backward_button));
        end
      end
      outstanding <= expected_words.size();
    end
  end

endmodule

@@ test/arm_hold_and_ramp_control_tb.sv @@
`timescale 1ns / 100ps
// arm_hold_and_ramp_control_tb: drives control ticks and register writes into the
// arm controller and gives the verdict; checking lives in arm_drive_checker (ahrc_pkg).
module arm_hold_and_ramp_control_tb;
  import ahrc_pkg::*;

  // The slowest word is a hold tick that fires the integral cap; with sender gaps,
  // receiver stalls and one long hold-off the run sits far below this limit.
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 40;   // covers a capped hold tick still in flight
  localparam int HOLD_OFF_CYCLES = 400;  // long receiver hold-off, fills the block

  typedef struct {
    logic [ANGLE_FIELD_W-1:0] angle;
    logic signed [SPEED_W-1:0] speed;
    logic                      fwd;
    logic                      bwd;
    logic                      lock;
    logic                      busy;
    logic [TIME_W-1:0]         now;
  } tick_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          tick_valid;
  logic                          tick_stall;
  logic [ANGLE_FIELD_W-1:0]      arm_angle;
  logic signed [SPEED_W-1:0]     arm_speed;
  logic                          forward_button;
  logic                          backward_button;
  logic                          lock_request;
  logic                          lock_task_busy;
  logic [TIME_W-1:0]             now_ms;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic signed [DRIVE_W-1:0]     drive_power;
  logic                          stop_lock_task;

  int          mismatches;
  int          outstanding;
  bit          idle_on = 1'b1;       // random idling on both sides
  int          holdoff_requests = 0; // bumped by stimulus, served by the receiver
  int          holdoff_seen = 0;
  int          holdoff_left = 0;
  int          cycles = 0;
  logic [TIME_W-1:0] ms;             // running millisecond clock of the random part

  arm_hold_and_ramp_control uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .tick_valid      (tick_valid),
    .tick_stall      (tick_stall),
    .arm_angle       (arm_angle),
    .arm_speed       (arm_speed),
    .forward_button  (forward_button),
    .backward_button (backward_button),
    .lock_request    (lock_request),
    .lock_task_busy  (lock_task_busy),
    .now_ms          (now_ms),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .drive_power     (drive_power),
    .stop_lock_task  (stop_lock_task)
  );

  arm_drive_checker drive_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .tick_valid      (tick_valid),
    .tick_stall      (tick_stall),
    .arm_angle       (arm_angle),
    .arm_speed       (arm_speed),
    .forward_button  (forward_button),
    .backward_button (backward_button),
    .lock_request    (lock_request),
    .lock_task_busy  (lock_task_busy),
    .now_ms          (now_ms),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .drive_power     (drive_power),
    .stop_lock_task  (stop_lock_task),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  // The counter lives here so the hold-off length does not depend on the sender.
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_requests) begin
      holdoff_seen = holdoff_requests;
      holdoff_left = HOLD_OFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= idle_on && ($urandom_range(0, 99) < 28);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** arm_hold_and_ramp_control: FAILED **");
      $finish;
    end
  end

  function automatic tick_t mk_tick(
    input int angle, input int speed,
    input bit fwd, input bit bwd, input bit lock, input bit busy,
    input int now
  );
    tick_t t;
    t.angle = angle[ANGLE_FIELD_W-1:0];
    t.speed = speed[SPEED_W-1:0];
    t.fwd   = fwd;
    t.bwd   = bwd;
    t.lock  = lock;
    t.busy  = busy;
    t.now   = now[TIME_W-1:0];
    return t;
  endfunction

  function automatic int clamp_angle(input int a);
    if (a < 0) return 0;
    if (a > 4095) return 4095;
    return a;
  endfunction

  // Mostly slow arms (around the relatch and settle thresholds), sometimes any speed.
  function automatic int pick_speed();
    if ($urandom_range(0, 2) == 0) return int'($urandom_range(0, 2047)) - 1024;
    return int'($urandom_range(0, 24)) - 12;
  endfunction

  // Offer one tick word; valid may drop for random gaps first, never while stalled.
  task automatic send_tick(input tick_t t);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 28) begin
        tick_valid <= 1'b0;
        @(posedge clk);
      end
    end
    tick_valid      <= 1'b1;
    arm_angle       <= t.angle;
    arm_speed       <= t.speed;
    forward_button  <= t.fwd;
    backward_button <= t.bwd;
    lock_request    <= t.lock;
    lock_task_busy  <= t.busy;
    now_ms          <= t.now;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
  endtask

  // Quiet the tick side and wait until every predicted word has come back, then let
  // a tick that makes no word (lock/busy) finish too.
  task automatic wait_drained();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic set_registers(
    input logic [CFG_DATA_W-1:0] kp_init, kp_set, ki, kd,
    input logic [CFG_DATA_W-1:0] max_pwr, upper, lower, ramp0
  );
    wait_drained();
    put_reg(REG_HOLD_GAIN_INITIAL, kp_init);
    put_reg(REG_HOLD_GAIN_SETTLED, kp_set);
    put_reg(REG_INTEGRAL_GAIN, ki);
    put_reg(REG_SPEED_GAIN, kd);
    put_reg(REG_MAX_HOLD_POWER, max_pwr);
    put_reg(REG_UPPER_ANGLE_LIMIT, upper);
    put_reg(REG_LOWER_ANGLE_LIMIT, lower);
    put_reg(REG_RAMP_START_POWER, ramp0);
    cfg_write <= 1'b0;
  endtask

  // Random part built from plausible stretches: hold runs where the arm drifts off
  // its target over hundreds of ms, button ramps, lock interruptions, and pure noise.
  // Lock/busy ticks are not counted, since the block only drops its mode on them.
  task automatic random_ticks(input int count);
    int    done_items, run_len, kind, base, slope, buttons;
    bit    lk, bz;
    tick_t t;
    done_items = 0;
    ms = TIME_W'($urandom());
    while (done_items < count) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 5) == 0) begin
        // park near a travel end so the limit overrides get hit
        base = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 120)
                                           : 4095 - int'($urandom_range(0, 120));
      end else begin
        base = $urandom_range(0, 4095);
      end
      if (kind < 45) begin
        run_len = $urandom_range(3, 40);
        if (run_len > count - done_items) run_len = count - done_items;
        slope   = int'($urandom_range(0, 80)) - 40;
        for (int i = 0; i < run_len; i++) begin
          ms += TIME_W'($urandom_range(7, 25));
          send_tick(mk_tick(clamp_angle(base + slope * i + int'($urandom_range(0, 16)) - 8),
                            pick_speed(), 1'b0, 1'b0, 1'b0, 1'b0, ms));
        end
        done_items += run_len;
      end else if (kind < 80) begin
        run_len = $urandom_range(2, 45);
        if (run_len > count - done_items) run_len = count - done_items;
        slope   = int'($urandom_range(0, 40)) - 20;
        buttons = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 19) == 0) buttons = $urandom_range(1, 3);
          ms += TIME_W'($urandom_range(7, 25));
          send_tick(mk_tick(clamp_angle(base + slope * i), pick_speed(),
                            buttons[0], buttons[1], 1'b0, 1'b0, ms));
        end
        done_items += run_len;
      end else if (kind < 88) begin
        run_len = $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++) begin
          lk = 1'($urandom_range(0, 1));
          bz = !lk || ($urandom_range(0, 1) != 0);
          ms += TIME_W'($urandom_range(7, 25));
          send_tick(mk_tick(base, pick_speed(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            lk, bz, ms));
        end
      end else begin
        run_len = $urandom_range(1, 4);
        for (int i = 0; i < run_len; i++) begin
          t = mk_tick($urandom_range(0, 4095), $urandom_range(0, 2047),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      $urandom_range(0, 65535));
          send_tick(t);
          if (!t.lock && !t.busy) done_items++;
        end
      end
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_HOLD_GAIN_INITIAL;
    cfg_data        <= '0;
    tick_valid      <= 1'b0;
    arm_angle       <= '0;
    arm_speed       <= '0;
    forward_button  <= 1'b0;
    backward_button <= 1'b0;
    lock_request    <= 1'b0;
    lock_task_busy  <= 1'b0;
    now_ms          <= '0;
    ms              = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset register values.
    set_registers(CFG_DATA_W'(HOLD_GAIN_INITIAL_RST), CFG_DATA_W'(HOLD_GAIN_SETTLED_RST),
                  CFG_DATA_W'(INTEGRAL_GAIN_RST), CFG_DATA_W'(SPEED_GAIN_RST),
                  CFG_DATA_W'(MAX_HOLD_POWER_RST), CFG_DATA_W'(UPPER_LIMIT_RST),
                  CFG_DATA_W'(LOWER_LIMIT_RST), CFG_DATA_W'(RAMP_START_RST));
    send_tick(mk_tick(2000, 0, 0, 0, 0, 0, 1000));      // hold entry, zero error
    send_tick(mk_tick(2100, 20, 0, 0, 0, 0, 1100));     // moving early: target relatches
    send_tick(mk_tick(2400, 0, 0, 0, 0, 0, 1250));      // positive error
    send_tick(mk_tick(1500, -1024, 0, 0, 0, 0, 1700));  // late but fast: gain not settled
    send_tick(mk_tick(1600, 3, 0, 0, 0, 0, 1800));      // late and slow: settled gain
    send_tick(mk_tick(1700, 1023, 0, 0, 0, 0, 1820));   // full speed damping
    send_tick(mk_tick(4095, 0, 0, 0, 0, 0, 1840));      // upper travel override
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 1860));         // lower travel override
    send_tick(mk_tick(30, 0, 0, 0, 1, 0, 1880));        // lock: no word, mode dropped
    send_tick(mk_tick(2000, 0, 0, 0, 0, 1, 1900));      // lock task busy: no word
    send_tick(mk_tick(2000, 0, 1, 0, 0, 0, 1920));      // ramp begins, stop flag
    send_tick(mk_tick(2000, 0, 1, 0, 0, 0, 1940));
    send_tick(mk_tick(4095, 0, 0, 1, 0, 0, 1960));      // lowering at the top: 15
    send_tick(mk_tick(2000, 0, 1, 1, 0, 0, 1980));      // both buttons: zero drive
    send_tick(mk_tick(10, 0, 1, 0, 0, 0, 2000));        // raising at the bottom: 15
    send_tick(mk_tick(3000, 0, 0, 0, 0, 0, 65500));     // hold entry just before wrap
    send_tick(mk_tick(3100, -5, 0, 0, 0, 0, 120));      // elapsed across the wrap
    send_tick(mk_tick(3100, 10, 0, 0, 0, 0, 600));      // settle at the speed boundary
    send_tick(mk_tick(3100, 0, 1, 1, 0, 0, 700));       // hold straight into ramp
    send_tick(mk_tick(3100, 0, 0, 0, 1, 1, 720));       // lock and busy together
    send_tick(mk_tick(3100, 0, 0, 0, 0, 0, 65535));     // fresh hold at the top of time

    // Defaults again, with one long receiver hold-off while ticks keep coming.
    holdoff_requests++;
    random_ticks(120);

    // Every gain and the power and upper limits at their top, lower limit 0, ramp from full power.
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'd127, 16'd4095, 16'd0, 16'd127);
    random_ticks(90);

    // Everything at the bottom: no gain, no integral, limits crossed over.
    set_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd0);
    random_ticks(70);

    // Small power limit, tiny integral gain, narrowed travel; no idling on either side.
    set_registers(16'd4000, 16'd30000, 16'd1, 16'd2000, 16'd3, 16'd3500, 16'd500, 16'd80);
    idle_on = 1'b0;
    random_ticks(120);
    idle_on = 1'b1;

    // Full-width random writes; narrow registers keep only their low bits.
    set_registers(CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(0, 65535)),
                  CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(0, 65535)),
                  CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(0, 65535)),
                  CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(0, 65535)));
    random_ticks(150);

    wait_drained();
    if (mismatches == 0) begin
      $display("** arm_hold_and_ramp_control: PASSED **");
    end else begin
      $display("** arm_hold_and_ramp_control: FAILED **");
    end
    $finish;
  end

endmodule
